// File: rtl/cordic_rotate_vector_top_macros.svh
// Assertion helpers shared by the CORDIC datapath cells.
// Every macro samples on clk and is quiet while rst_n is low.
`ifndef CORDIC_ROTATE_VECTOR_TOP_MACROS_SVH
`define CORDIC_ROTATE_VECTOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/crv_pkg.sv
package crv_pkg;

    // Port field width, fixed by the interface
    localparam int FIELD_WIDTH = 16;

    // Defaults for the top level parameters
    localparam int DATA_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 13;
    localparam int ITERATIONS_DEF  = 16;
    localparam int SCALE_STEPS_DEF = 6;

    // Gain compensation steps: v +/-= v >>> shift
    localparam int SCALE_TABLE_LEN = 6;
    localparam int SCALE_SHIFT [SCALE_TABLE_LEN] = '{1, 3, 4, 6, 11, 14};
    localparam bit SCALE_ADD   [SCALE_TABLE_LEN] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

    // Mode codes
    localparam logic MODE_ROTATE = 1'b0;
    localparam logic MODE_VECTOR = 1'b1;

    // Control word handed from cell to cell
    typedef struct packed {
        logic valid;
        logic vec;
    } crv_ctl_t;

    // atan(2^-j) rounded to nearest (ties up) at frac fractional bits.
    // Deep entries sit just under 2^-j: they round to that power of two,
    // or to zero once 2^-j is half an LSB or less.
    function automatic logic [63:0] atan_rom(input int j, input int frac);
        real v;
        if (j >= 21) begin
            if (j > frac)
                return '0;
            return 64'd1 << (frac - j);
        end
        v = $atan(2.0 ** (-j)) * (2.0 ** frac);
        return 64'(longint'($floor(v + 0.5)));
    endfunction

endpackage

// File: rtl/crv_iter_cell.sv
`include "cordic_rotate_vector_top_macros.svh"

module crv_iter_cell import crv_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int STAGE      = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  crv_ctl_t                     ctl_in,
    input  logic signed [DATA_WIDTH-1:0] x_in,
    input  logic signed [DATA_WIDTH-1:0] y_in,
    input  logic signed [DATA_WIDTH-1:0] th_in,
    output crv_ctl_t                     ctl_out,
    output logic signed [DATA_WIDTH-1:0] x_out,
    output logic signed [DATA_WIDTH-1:0] y_out,
    output logic signed [DATA_WIDTH-1:0] th_out
);

    localparam logic signed [DATA_WIDTH-1:0] ANGLE =
        DATA_WIDTH'(atan_rom(STAGE, FRAC_BITS));

    crv_ctl_t                     ctl_reg;
    logic signed [DATA_WIDTH-1:0] x_reg, y_reg, th_reg;
    logic signed [DATA_WIDTH-1:0] x_next, y_next, th_next;
    logic signed [DATA_WIDTH-1:0] xs, ys;
    logic                         rot_pos;

    // Micro-rotation direction: follow the angle sign, or drive y to zero
    assign rot_pos = ctl_in.vec ? y_in[DATA_WIDTH-1] : !th_in[DATA_WIDTH-1];
    assign xs      = x_in >>> STAGE;
    assign ys      = y_in >>> STAGE;

    always_comb
    begin
        if (rot_pos)
        begin
            x_next  = x_in - ys;
            y_next  = y_in + xs;
            th_next = th_in - ANGLE;
        end
        else
        begin
            x_next  = x_in + ys;
            y_next  = y_in - xs;
            th_next = th_in + ANGLE;
        end
    end

    // Control word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    // Datapath word
    always_ff @(posedge clk)
    begin
        if (ctl_in.valid)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            th_reg <= th_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign th_out  = th_reg;

    `CRV_ASSERT_NEXT(a_valid_moves, ctl_in.valid, ctl_out.valid, "word lost in cell")
    `CRV_ASSERT_NEXT(a_no_phantom, !ctl_in.valid, !ctl_out.valid, "word invented in cell")
    `CRV_ASSERT_NEXT(a_mode_kept, ctl_in.valid, ctl_out.vec == $past(ctl_in.vec),
        "mode changed in cell")
    `CRV_ASSERT_NEXT(a_angle_step, ctl_in.valid,
        (th_out == $past(th_in) + ANGLE) || (th_out == $past(th_in) - ANGLE),
        "angle step is not one table entry")

endmodule

// File: rtl/crv_scale_cell.sv
module crv_scale_cell import crv_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int SHIFT      = 1,
    parameter bit ADD        = 1'b0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  crv_ctl_t                     ctl_in,
    input  logic signed [DATA_WIDTH-1:0] x_in,
    input  logic signed [DATA_WIDTH-1:0] y_in,
    input  logic signed [DATA_WIDTH-1:0] th_in,
    output crv_ctl_t                     ctl_out,
    output logic signed [DATA_WIDTH-1:0] x_out,
    output logic signed [DATA_WIDTH-1:0] y_out,
    output logic signed [DATA_WIDTH-1:0] th_out
);

    crv_ctl_t                     ctl_reg;
    logic signed [DATA_WIDTH-1:0] x_reg, y_reg, th_reg;
    logic signed [DATA_WIDTH-1:0] x_next, y_next;

    // One shift-add gain step on both coordinates
    assign x_next = ADD ? (x_in + (x_in >>> SHIFT)) : (x_in - (x_in >>> SHIFT));
    assign y_next = ADD ? (y_in + (y_in >>> SHIFT)) : (y_in - (y_in >>> SHIFT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.valid)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            th_reg <= th_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign th_out  = th_reg;

endmodule

// File: rtl/cordic_rotate_vector_top.sv
// Channel  | Ports                             | Handshake
// ---------+-----------------------------------+-------------------------------
// input    | x_in, y_in, mode, angle_in        | taken when start && !busy
// result   | x_out, y_out, angle_out           | done high for one cycle
//
// Fully pipelined: one word accepted per cycle, busy is never raised.
// Every CORDIC cell and every gain step cell holds a register for the word.
// rst_n clears the valid bits of all cells; words in flight are dropped.
// The result side cannot stall, so nothing ever backs up.
module cordic_rotate_vector_top import crv_pkg::*; #(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int ITERATIONS  = ITERATIONS_DEF,
    parameter int SCALE_STEPS = SCALE_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [FIELD_WIDTH-1:0] x_in,
    input  logic signed [FIELD_WIDTH-1:0] y_in,
    input  logic                          mode,
    input  logic signed [FIELD_WIDTH-1:0] angle_in,
    output logic                          done,
    output logic signed [FIELD_WIDTH-1:0] x_out,
    output logic signed [FIELD_WIDTH-1:0] y_out,
    output logic signed [FIELD_WIDTH-1:0] angle_out
);

    localparam int NSCALE = (SCALE_STEPS < SCALE_TABLE_LEN) ? SCALE_STEPS : SCALE_TABLE_LEN;
    localparam int NCELLS = ITERATIONS + NSCALE;

    crv_ctl_t                     ctl_pipe [0:NCELLS];
    logic signed [DATA_WIDTH-1:0] x_pipe   [0:NCELLS];
    logic signed [DATA_WIDTH-1:0] y_pipe   [0:NCELLS];
    logic signed [DATA_WIDTH-1:0] th_pipe  [0:NCELLS];
    logic signed [DATA_WIDTH-1:0] x_ext, y_ext, a_ext;
    logic                         vec;

    assign busy = 1'b0;

    // Bring the port fields to the datapath width
    assign x_ext = DATA_WIDTH'(x_in);
    assign y_ext = DATA_WIDTH'(y_in);
    assign a_ext = DATA_WIDTH'(angle_in);
    assign vec   = (mode == MODE_VECTOR);

    // Entry: rotation starts from the negated angle; vectoring reflects
    // left half-plane vectors through the origin
    always_comb
    begin
        ctl_pipe[0].valid = start && !busy;
        ctl_pipe[0].vec   = vec;
        if (vec)
        begin
            x_pipe[0]  = x_ext[DATA_WIDTH-1] ? -x_ext : x_ext;
            y_pipe[0]  = x_ext[DATA_WIDTH-1] ? -y_ext : y_ext;
            th_pipe[0] = '0;
        end
        else
        begin
            x_pipe[0]  = x_ext;
            y_pipe[0]  = y_ext;
            th_pipe[0] = -a_ext;
        end
    end

    // CORDIC micro-rotation cells
    for (genvar j = 0; j < ITERATIONS; j++)
    begin : g_iter
        crv_iter_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .STAGE      (j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_pipe[j]),
            .x_in    (x_pipe[j]),
            .y_in    (y_pipe[j]),
            .th_in   (th_pipe[j]),
            .ctl_out (ctl_pipe[j+1]),
            .x_out   (x_pipe[j+1]),
            .y_out   (y_pipe[j+1]),
            .th_out  (th_pipe[j+1])
        );
    end

    // Gain compensation cells
    for (genvar i = 0; i < NSCALE; i++)
    begin : g_scale
        crv_scale_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .SHIFT      (SCALE_SHIFT[i]),
            .ADD        (SCALE_ADD[i])
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_pipe[ITERATIONS+i]),
            .x_in    (x_pipe[ITERATIONS+i]),
            .y_in    (y_pipe[ITERATIONS+i]),
            .th_in   (th_pipe[ITERATIONS+i]),
            .ctl_out (ctl_pipe[ITERATIONS+i+1]),
            .x_out   (x_pipe[ITERATIONS+i+1]),
            .y_out   (y_pipe[ITERATIONS+i+1]),
            .th_out  (th_pipe[ITERATIONS+i+1])
        );
    end

    // Result word
    assign done      = ctl_pipe[NCELLS].valid;
    assign x_out     = FIELD_WIDTH'(x_pipe[NCELLS]);
    assign y_out     = FIELD_WIDTH'(y_pipe[NCELLS]);
    assign angle_out = FIELD_WIDTH'(th_pipe[NCELLS]);

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import crv_pkg::*;

    typedef logic signed [FIELD_WIDTH-1:0] fld_t;

    // Datapath is configured at the default widths
    localparam int CORDIC_STAGES = ITERATIONS_DEF;
    localparam int GAIN_STEPS    = SCALE_STEPS_DEF;
    localparam int LATENCY       = CORDIC_STAGES + GAIN_STEPS;
    localparam int ITEM_COUNT    = 450;
    localparam int MAX_REPORTS   = 10;

    // atan(2^-j) at 13 fractional bits, nearest rounding
    localparam fld_t ATAN_TABLE [16] = '{
        16'sd6434, 16'sd3798, 16'sd2007, 16'sd1019, 16'sd511, 16'sd256, 16'sd128, 16'sd64,
        16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2, 16'sd1, 16'sd0, 16'sd0
    };

    // Gain trim: v -= v>>>1, then v += v>>>3, 4, 6, 11, then v -= v>>>14
    localparam int GAIN_SHIFT [6] = '{1, 3, 4, 6, 11, 14};
    localparam bit GAIN_PLUS  [6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

    typedef struct {
        fld_t x;
        fld_t y;
        fld_t angle;
    } cordic_word_t;

    // Tracks expected result words and compares them against the block
    class cordic_tracker;
        cordic_word_t expected_words [$];
        int           fail_count;

        function new();
            fail_count = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // One full CORDIC evaluation at 16-bit wrapping arithmetic
        function cordic_word_t cordic_eval(fld_t xi, fld_t yi, logic m, fld_t ai);
            fld_t         x;
            fld_t         y;
            fld_t         th;
            fld_t         xs;
            fld_t         ys;
            cordic_word_t r;
            x = xi;
            y = yi;
            if (m == MODE_ROTATE)
            begin
                th = -ai;
            end
            else
            begin
                th = '0;
                // left half plane: reflect through the origin
                if (x < 0)
                begin
                    x = -x;
                    y = -y;
                end
            end
            for (int j = 0; j < CORDIC_STAGES; j++)
            begin
                xs = x >>> j;
                ys = y >>> j;
                if ((m == MODE_ROTATE && th >= 0) || (m == MODE_VECTOR && y < 0))
                begin
                    x  = x - ys;
                    y  = y + xs;
                    th = th - ATAN_TABLE[j];
                end
                else
                begin
                    x  = x + ys;
                    y  = y - xs;
                    th = th + ATAN_TABLE[j];
                end
            end
            for (int i = 0; i < GAIN_STEPS && i < 6; i++)
            begin
                if (GAIN_PLUS[i])
                begin
                    x = x + (x >>> GAIN_SHIFT[i]);
                    y = y + (y >>> GAIN_SHIFT[i]);
                end
                else
                begin
                    x = x - (x >>> GAIN_SHIFT[i]);
                    y = y - (y >>> GAIN_SHIFT[i]);
                end
            end
            r.x     = x;
            r.y     = y;
            r.angle = th;
            return r;
        endfunction

        function void note_word(fld_t xi, fld_t yi, logic m, fld_t ai);
            expected_words.push_back(cordic_eval(xi, yi, m, ai));
        endfunction

        function void check_word(fld_t xo, fld_t yo, fld_t ao);
            cordic_word_t want;
            if (expected_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result word with none expected: x=%0d y=%0d angle=%0d",
                             $time, xo, yo, ao);
                return;
            end
            want = expected_words.pop_front();
            if (want.x !== xo || want.y !== yo || want.angle !== ao)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: mismatch exp x=%0d y=%0d angle=%0d got x=%0d y=%0d angle=%0d",
                             $time, want.x, want.y, want.angle, xo, yo, ao);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    fld_t x_in;
    fld_t y_in;
    logic mode;
    fld_t angle_in;
    logic done;
    fld_t x_out;
    fld_t y_out;
    fld_t angle_out;

    cordic_tracker tracker = new();
    bit            burst;

    cordic_rotate_vector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .x_in      (x_in),
        .y_in      (y_in),
        .mode      (mode),
        .angle_in  (angle_in),
        .done      (done),
        .x_out     (x_out),
        .y_out     (y_out),
        .angle_out (angle_out)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("cordic_rotate_vector_top verification failed");
        $finish;
    end

    // Observe accepted input words and result words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                tracker.note_word(x_in, y_in, mode, angle_in);
            if (done)
                tracker.check_word(x_out, y_out, angle_out);
        end
    end

    // Present one word after a random gap (none in a burst), hold it until taken
    task send_word(input fld_t xv, input fld_t yv, input logic mv, input fld_t av);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            @(negedge clk);
            start    <= 1'b0;
            x_in     <= fld_t'($urandom);
            y_in     <= fld_t'($urandom);
            mode     <= 1'($urandom);
            angle_in <= fld_t'($urandom);
        end
        @(negedge clk);
        start    <= 1'b1;
        x_in     <= xv;
        y_in     <= yv;
        mode     <= mv;
        angle_in <= av;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending until every outstanding result has come back
    task drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Random word: mostly in-range vectors and angles, the rest full range
    task send_random_word();
        int   pick;
        fld_t xv;
        fld_t yv;
        fld_t av;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            xv = fld_t'($signed($urandom_range(0, 32767)) - 16384);
            yv = fld_t'($signed($urandom_range(0, 32767)) - 16384);
            av = fld_t'($signed($urandom_range(0, 51472)) - 25736);
        end
        else
        begin
            xv = fld_t'($urandom);
            yv = fld_t'($urandom);
            av = fld_t'($urandom);
        end
        send_word(xv, yv, 1'($urandom), av);
    endtask

    // Main sequence
    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        x_in     = '0;
        y_in     = '0;
        mode     = MODE_ROTATE;
        angle_in = '0;
        burst    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words: rotation
        send_word(16'sd8192, 16'sd0, MODE_ROTATE, 16'sd0);
        send_word(16'sd8192, 16'sd0, MODE_ROTATE, 16'sd12868);
        send_word(16'sd0, 16'sd8192, MODE_ROTATE, -16'sd12868);
        send_word(16'sd4096, 16'sd4096, MODE_ROTATE, 16'sd25736);
        send_word(16'sd32767, 16'sd32767, MODE_ROTATE, 16'sd32767);
        // most negative angle: its negation wraps to itself
        send_word(-16'sd32768, -16'sd32768, MODE_ROTATE, -16'sd32768);
        send_word(16'sd32767, -16'sd32768, MODE_ROTATE, 16'sd6434);
        send_word(16'sd0, 16'sd0, MODE_ROTATE, -16'sd1);

        // Directed words: vectoring
        send_word(16'sd8192, 16'sd8192, MODE_VECTOR, 16'sd1234);
        send_word(16'sd8192, -16'sd8192, MODE_VECTOR, -16'sd32768);
        // left half plane gets reflected
        send_word(-16'sd8192, 16'sd4096, MODE_VECTOR, 16'sd0);
        send_word(-16'sd8192, -16'sd4096, MODE_VECTOR, 16'sd32767);
        send_word(-16'sd1, 16'sd0, MODE_VECTOR, 16'sd0);
        send_word(16'sd0, 16'sd8192, MODE_VECTOR, 16'sd0);
        send_word(16'sd0, -16'sd8192, MODE_VECTOR, 16'sd0);
        send_word(16'sd0, 16'sd0, MODE_VECTOR, 16'sd0);
        // reflecting the most negative x wraps back onto itself
        send_word(-16'sd32768, -16'sd32768, MODE_VECTOR, 16'sd0);
        send_word(-16'sd32768, 16'sd32767, MODE_VECTOR, 16'sd0);
        send_word(16'sd32767, 16'sd32767, MODE_VECTOR, 16'sd0);
        send_word(16'sd32767, 16'sd0, MODE_VECTOR, 16'sd0);
        drain_results();

        // Random words, in bursts and gappy stretches chosen at random
        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            if (n % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (n == ITEM_COUNT / 2)
                drain_results();
            send_random_word();
        end
        @(negedge clk);
        start <= 1'b0;

        // Wait out the pipeline
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (tracker.fail_count == 0 && tracker.pending() == 0)
            $display("cordic_rotate_vector_top verification clean");
        else
            $display("cordic_rotate_vector_top verification failed");
        $finish;
    end

endmodule
